// ===== src/lsepc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsepc_pkg
// Shared types, constants and color helpers of the LED strip pixel color block.
// ----------------------------------------------------------------------------
package lsepc_pkg;

   localparam int PIX_W   = 6;
   localparam int STEP_W  = 8;
   localparam int PHASE_W = 2;
   localparam int MODE_W  = 3;
   localparam int CNT_W   = 7;
   localparam int CH_W    = 8;
   localparam int D_W     = 6;
   localparam int SLOPE_W = 6;
   localparam int PROD_W  = D_W + SLOPE_W;
   localparam int SUB_W   = PROD_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CH_W-1:0]  WHEEL_SEG1   = 8'd85;
   localparam logic [CH_W-1:0]  WHEEL_SEG2   = 8'd170;
   localparam logic [CH_W-1:0]  CH_FULL      = 8'd255;
   localparam logic [8:0]       WHEEL_MOD    = 9'd255;
   localparam logic [CH_W-1:0]  METEOR_FLOOR = 8'd200;
   localparam logic [SUB_W-1:0] METEOR_DROP  = 13'd200;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_PIXELS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_RED   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_GREEN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_BLUE  = 2'd3;

   typedef enum logic [MODE_W-1:0] {
      MODE_RAINBOW       = 3'd0,
      MODE_CYCLE         = 3'd1,
      MODE_CHASE         = 3'd2,
      MODE_CHASE_RAINBOW = 3'd3,
      MODE_METEOR        = 3'd4
   } mode_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      mode_type             mode;
      logic                 blank;
      logic                 chase_hit;
      logic                 on_trail;
      logic [STEP_W-1:0]    step;
      logic [CH_W-1:0]      pos;
      logic [D_W-1:0]       d;
      logic [SLOPE_W-1:0]   excess;
      logic [CNT_W-1:0]     rem;
      logic [CH_W-1:0]      quo;
      logic [CNT_W-1:0]     count;
   } stage_a_type;

   typedef struct packed {
      mode_type             mode;
      logic                 blank;
      logic                 chase_hit;
      logic                 on_trail;
      logic [STEP_W-1:0]    step;
      logic [CH_W-1:0]      pos;
      logic [D_W-1:0]       d;
      logic [SLOPE_W-1:0]   slope;
      logic [CNT_W-1:0]     rem;
      logic [CH_W-1:0]      quo;
      logic [CNT_W-1:0]     count;
   } stage_b_type;

   typedef struct packed {
      mode_type             mode;
      logic                 blank;
      logic                 chase_hit;
      logic                 on_trail;
      logic [CH_W-1:0]      pos;
      logic [SUB_W-1:0]     sub;
      logic [CNT_W-1:0]     rem;
      logic [CNT_W-1:0]     count;
   } stage_c_type;

   function automatic rgb_type wheel(input logic [CH_W-1:0] p);
      logic [CH_W-1:0] w;
      logic [CH_W-1:0] v;
      logic [8:0]      tv;
      logic [CH_W-1:0] t;
      rgb_type         c;
      w = ~p;
      if (w < WHEEL_SEG1) begin
         v = w;
      end else if (w < WHEEL_SEG2) begin
         v = w - WHEEL_SEG1;
      end else begin
         v = w - WHEEL_SEG2;
      end
      tv = {v, 1'b0} + {1'b0, v};
      t  = tv[CH_W-1:0];
      if (w < WHEEL_SEG1) begin
         c = '{red: CH_FULL - t, green: '0, blue: t};
      end else if (w < WHEEL_SEG2) begin
         c = '{red: '0, green: t, blue: CH_FULL - t};
      end else begin
         c = '{red: t, green: CH_FULL - t, blue: '0};
      end
      return c;
   endfunction

   function automatic logic [1:0] mod3(input logic [PIX_W-1:0] x);
      logic [1:0] r;
      logic [2:0] t;
      r = '0;
      for (int i = PIX_W - 1; i >= 0; i--) begin
         t = {r, x[i]};
         r = (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
      end
      return r;
   endfunction

   function automatic logic [CH_W-1:0] trail_channel(input logic [CH_W-1:0] fill,
                                                      input logic [SUB_W-1:0] sub);
      logic [CH_W-1:0] res;
      if ({{(SUB_W-CH_W){1'b0}}, fill} > sub) begin
         res = fill - sub[CH_W-1:0];
      end else begin
         res = '0;
      end
      return res;
   endfunction

endpackage

// ===== src/lsepc_req_if.sv =====
// ----------------------------------------------------------------------------
// lsepc_req_if
// Request channel: one pixel word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsepc_req_if
   import lsepc_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [STEP_W-1:0]  step;
   logic [PHASE_W-1:0] phase;
   logic [PIX_W-1:0]   pixel_index;

   modport source (output valid, mode, step, phase, pixel_index, input ready);
   modport sink   (input valid, mode, step, phase, pixel_index, output ready);
endinterface

// ===== src/lsepc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lsepc_rsp_if
// Response channel: one color word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsepc_rsp_if
   import lsepc_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] out_red;
   logic [CH_W-1:0] out_green;
   logic [CH_W-1:0] out_blue;

   modport source (output valid, out_red, out_green, out_blue, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ===== src/lsepc_div_slice.sv =====
// ----------------------------------------------------------------------------
// lsepc_div_slice
// STEPS restoring division steps of pixel*256/count, one quotient bit each.
// ----------------------------------------------------------------------------
module lsepc_div_slice
   import lsepc_pkg::*;
#(
   parameter int STEPS = 3
) (
   input  logic [CNT_W-1:0] rem_in,
   input  logic [CH_W-1:0]  quo_in,
   input  logic [CNT_W-1:0] count,
   output logic [CNT_W-1:0] rem_out,
   output logic [CH_W-1:0]  quo_out
);

   always_comb begin
      logic [CNT_W:0]   r2;
      logic [CNT_W-1:0] r;
      logic [CH_W-1:0]  q;
      r = rem_in;
      q = quo_in;
      for (int i = 0; i < STEPS; i++) begin
         r2 = {r, 1'b0};
         if (r2 >= {1'b0, count}) begin
            r2 = r2 - {1'b0, count};
            q  = {q[CH_W-2:0], 1'b1};
         end else begin
            q  = {q[CH_W-2:0], 1'b0};
         end
         r = r2[CNT_W-1:0];
      end
      rem_out = r;
      quo_out = q;
   end

endmodule

// ===== src/lsepc_front.sv =====
// ----------------------------------------------------------------------------
// lsepc_front
// First stage: decode, wheel positions, chase and trail tests, divider start.
// ----------------------------------------------------------------------------
module lsepc_front
   import lsepc_pkg::*;
#(
   parameter int TRAIL_LENGTH = 15
) (
   input  logic [MODE_W-1:0]  mode,
   input  logic [STEP_W-1:0]  step,
   input  logic [PHASE_W-1:0] phase,
   input  logic [PIX_W-1:0]   pixel_index,
   input  logic [CNT_W-1:0]   count,
   input  rgb_type            fill,
   output stage_a_type        a
);

   logic [8:0]       sum3;
   logic [8:0]       diff;
   logic [CH_W-1:0]  mx;
   logic [CNT_W-1:0] rem;
   logic [CH_W-1:0]  quo;

   lsepc_div_slice #(.STEPS(3)) u_div (
      .rem_in  ({1'b0, pixel_index}),
      .quo_in  ('0),
      .count   (count),
      .rem_out (rem),
      .quo_out (quo)
   );

   always_comb begin
      sum3 = {3'b0, pixel_index} - {7'b0, phase} + {1'b0, step};
      if (sum3 >= WHEEL_MOD) begin
         sum3 = sum3 - WHEEL_MOD;
      end
      diff = {1'b0, step} - {3'b0, pixel_index};
      mx = fill.red;
      if (fill.green > mx) mx = fill.green;
      if (fill.blue > mx) mx = fill.blue;

      a.mode      = mode_type'(mode);
      a.blank     = ({1'b0, pixel_index} >= count);
      a.chase_hit = ({2'b0, mod3(pixel_index)} == {2'b0, phase});
      a.on_trail  = !diff[8] && (32'(diff[7:0]) < TRAIL_LENGTH);
      a.step      = step;
      a.pos       = (mode_type'(mode) == MODE_CHASE_RAINBOW) ? sum3[CH_W-1:0]
                                                             : {2'b0, pixel_index} + step;
      a.d         = diff[D_W-1:0];
      a.excess    = (mx >= METEOR_FLOOR) ? SLOPE_W'(mx - METEOR_FLOOR) : '0;
      a.rem       = rem;
      a.quo       = quo;
      a.count     = count;
   end

endmodule

// ===== src/lsepc_back.sv =====
// ----------------------------------------------------------------------------
// lsepc_back
// Last stage: wheel colors, meteor trail fade and the per-mode color select.
// ----------------------------------------------------------------------------
module lsepc_back
   import lsepc_pkg::*;
(
   input  stage_c_type c,
   input  rgb_type     fill,
   output rgb_type     color
);

   rgb_type wc;
   rgb_type tc;

   always_comb begin
      wc = wheel(c.pos);
      tc.red   = trail_channel(fill.red, c.sub);
      tc.green = trail_channel(fill.green, c.sub);
      tc.blue  = trail_channel(fill.blue, c.sub);
      color = '0;
      case (c.mode)
         MODE_RAINBOW, MODE_CYCLE: color = wc;
         MODE_CHASE:               color = c.chase_hit ? fill : '0;
         MODE_CHASE_RAINBOW:       color = c.chase_hit ? wc : '0;
         MODE_METEOR:              color = c.on_trail ? tc : '0;
         default:                  color = '0;
      endcase
      if (c.blank) begin
         color = '0;
      end
   end

endmodule

// ===== src/led_strip_effect_pixel_color.sv =====
// ----------------------------------------------------------------------------
// led_strip_effect_pixel_color
// Four-stage pipeline giving the RGB color of one strip pixel per animation
// step for rainbow, rainbow cycle, theater chase, chase rainbow and meteor effects.
//
//   channel  dir  handshake        payload
//   req_ch   in   valid/ready      mode, step, phase, pixel_index
//   rsp_ch   out  valid/ready      out_red, out_green, out_blue
//   csr      in   csr_we           csr_index, csr_wdata
//
// one word per cycle sustained while rsp_ch.ready is high; rsp valid once the word has passed registers a, b, c, d
// the eight-bit rainbow cycle divide is split 3/3/2 bits over three stages
// each stage holds its word until the next frees up, bubbles close up
// reset clears valid bits and loads num_pixels 64, fill color black
// ----------------------------------------------------------------------------
module led_strip_effect_pixel_color
   import lsepc_pkg::*;
#(
   parameter int MAX_PIXELS   = 64,
   parameter int TRAIL_LENGTH = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   lsepc_req_if.sink             req_ch,
   lsepc_rsp_if.source           rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // slope by reciprocal multiply, exact for excess below 64
   localparam int SLOPE_SHIFT = 13;
   localparam int SLOPE_RECIP = (2 ** SLOPE_SHIFT + TRAIL_LENGTH - 1) / TRAIL_LENGTH;
   localparam int SPROD_W     = SLOPE_SHIFT + 1 + SLOPE_W;

   logic [CNT_W-1:0] num_pixels_ff;
   rgb_type          fill_ff;
   logic [CNT_W-1:0] count;

   logic        va_ff, vb_ff, vc_ff, vd_ff;
   logic        rdy_a, rdy_b, rdy_c, rdy_d;
   stage_a_type a_in, a_ff;
   stage_b_type b_in, b_ff;
   stage_c_type c_in, c_ff;
   rgb_type     d_in, d_ff;
   logic [CNT_W-1:0] rem_b, rem_c;
   logic [CH_W-1:0]  quo_b, quo_c;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_pixels_ff <= CNT_W'(64);
         fill_ff       <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_PIXELS: num_pixels_ff  <= csr_wdata[CNT_W-1:0];
            CSR_FILL_RED:   fill_ff.red    <= csr_wdata;
            CSR_FILL_GREEN: fill_ff.green  <= csr_wdata;
            CSR_FILL_BLUE:  fill_ff.blue   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign count = (32'(num_pixels_ff) > MAX_PIXELS) ? CNT_W'(MAX_PIXELS) : num_pixels_ff;

   // handshake chain
   assign rdy_d        = !vd_ff || rsp_ch.ready;
   assign rdy_c        = !vc_ff || rdy_d;
   assign rdy_b        = !vb_ff || rdy_c;
   assign rdy_a        = !va_ff || rdy_b;
   assign req_ch.ready = rdy_a;

   // stage a
   lsepc_front #(.TRAIL_LENGTH(TRAIL_LENGTH)) u_front (
      .mode        (req_ch.mode),
      .step        (req_ch.step),
      .phase       (req_ch.phase),
      .pixel_index (req_ch.pixel_index),
      .count       (count),
      .fill        (fill_ff),
      .a           (a_in)
   );

   // stage b: divide steps and slope
   lsepc_div_slice #(.STEPS(3)) u_div_b (
      .rem_in  (a_ff.rem),
      .quo_in  (a_ff.quo),
      .count   (a_ff.count),
      .rem_out (rem_b),
      .quo_out (quo_b)
   );

   always_comb begin
      logic [SPROD_W-1:0] sprod;
      sprod = SPROD_W'(a_ff.excess) * SPROD_W'(SLOPE_RECIP);
      b_in.mode      = a_ff.mode;
      b_in.blank     = a_ff.blank;
      b_in.chase_hit = a_ff.chase_hit;
      b_in.on_trail  = a_ff.on_trail;
      b_in.step      = a_ff.step;
      b_in.pos       = a_ff.pos;
      b_in.d         = a_ff.d;
      b_in.slope     = sprod[SLOPE_SHIFT +: SLOPE_W];
      b_in.rem       = rem_b;
      b_in.quo       = quo_b;
      b_in.count     = a_ff.count;
   end

   // stage c: last divide steps, wheel position, trail subtrahend
   lsepc_div_slice #(.STEPS(2)) u_div_c (
      .rem_in  (b_ff.rem),
      .quo_in  (b_ff.quo),
      .count   (b_ff.count),
      .rem_out (rem_c),
      .quo_out (quo_c)
   );

   always_comb begin
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(b_ff.slope) * PROD_W'(b_ff.d);
      c_in.mode      = b_ff.mode;
      c_in.blank     = b_ff.blank;
      c_in.chase_hit = b_ff.chase_hit;
      c_in.on_trail  = b_ff.on_trail;
      c_in.pos       = (b_ff.mode == MODE_CYCLE) ? quo_c + b_ff.step : b_ff.pos;
      c_in.sub       = {1'b0, prod} + ((b_ff.d != '0) ? METEOR_DROP : '0);
      c_in.rem       = rem_c;
      c_in.count     = b_ff.count;
   end

   // stage d: color
   lsepc_back u_back (
      .c     (c_ff),
      .fill  (fill_ff),
      .color (d_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= req_ch.valid;
         if (rdy_b) vb_ff <= va_ff;
         if (rdy_c) vc_ff <= vb_ff;
         if (rdy_d) vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) a_ff <= a_in;
      if (rdy_b) b_ff <= b_in;
      if (rdy_c) c_ff <= c_in;
      if (rdy_d) d_ff <= d_in;
   end

   assign rsp_ch.valid     = vd_ff;
   assign rsp_ch.out_red   = d_ff.red;
   assign rsp_ch.out_green = d_ff.green;
   assign rsp_ch.out_blue  = d_ff.blue;

   // divider remainder stays below the count for pixels on the strip
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (va_ff && !a_ff.blank) |-> (a_ff.rem < a_ff.count))
      else $error("divider remainder out of range in stage a");

   c_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (vc_ff && !c_ff.blank) |-> (c_ff.rem < c_ff.count))
      else $error("divider remainder out of range in stage c");

   c_hold: assert property (@(posedge clock) disable iff (reset)
      (vc_ff && !rdy_d) |=> (vc_ff && $stable(c_ff)))
      else $error("stage c word changed while stalled");

   blank_black: assert property (@(posedge clock) disable iff (reset)
      (vc_ff && rdy_d && (c_ff.blank || (c_ff.mode == MODE_METEOR && !c_ff.on_trail)))
      |=> (d_ff == '0))
      else $error("off-strip or off-trail pixel not black");

endmodule

// ===== dv/lsepc_color_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsepc_color_checker
// Monitors the pixel and color channels of the LED strip pixel color block.
// It tracks the strip registers, predicts the color of every accepted pixel
// word and compares each channel of the returned color words in order.
// ----------------------------------------------------------------------------
module lsepc_color_checker
   import lsepc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   lsepc_req_if                  req_mon,
   lsepc_rsp_if                  rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           mismatch_count,
   output int unsigned           colors_outstanding,
   output int unsigned           colors_checked
);

   localparam int STRIP_MAX    = 64;
   localparam int TAIL_LEN     = 15;
   localparam int TAIL_DROP    = 200;
   localparam int REPORT_LIMIT = 10;

   logic [CNT_W-1:0] strip_len;
   rgb_type          fill_color;
   rgb_type          color_due[$];

   function automatic rgb_type hue_at(input int p);
      int      w;
      rgb_type c;
      w = 255 - (p & 255);
      if (w < 85) begin
         c = '{red: 8'(255 - 3 * w), green: 8'd0, blue: 8'(3 * w)};
      end else if (w < 170) begin
         c = '{red: 8'd0, green: 8'(3 * (w - 85)), blue: 8'(255 - 3 * (w - 85))};
      end else begin
         c = '{red: 8'(3 * (w - 170)), green: 8'(255 - 3 * (w - 170)), blue: 8'd0};
      end
      return c;
   endfunction

   function automatic int faded(input int level, input int slope, input int behind);
      int drop;
      drop = slope * behind + ((behind >= 1) ? TAIL_DROP : 0);
      return (level > drop) ? level - drop : 0;
   endfunction

   function automatic rgb_type pixel_color(input logic [MODE_W-1:0]  mode,
                                           input logic [STEP_W-1:0]  step,
                                           input logic [PHASE_W-1:0] phase,
                                           input logic [PIX_W-1:0]   pixel);
      int      cnt;
      int      px;
      int      st;
      int      ph;
      int      behind;
      int      peak;
      int      slope;
      rgb_type c;
      px  = pixel;
      st  = step;
      ph  = phase;
      cnt = (strip_len < STRIP_MAX) ? strip_len : STRIP_MAX;
      c   = '0;
      if (px < cnt) begin
         case (mode)
            MODE_RAINBOW: c = hue_at(px + st);
            MODE_CYCLE: c = hue_at(px * 256 / cnt + st);
            MODE_CHASE: if (px % 3 == ph) c = fill_color;
            MODE_CHASE_RAINBOW: if (px % 3 == ph) c = hue_at((px - ph + st) % 255);
            MODE_METEOR: begin
               if (st >= px && st - px < TAIL_LEN) begin
                  behind = st - px;
                  peak = fill_color.red;
                  if (fill_color.green > peak) peak = fill_color.green;
                  if (fill_color.blue > peak) peak = fill_color.blue;
                  slope = (peak >= TAIL_DROP) ? (peak - TAIL_DROP) / TAIL_LEN : 0;
                  c.red   = 8'(faded(fill_color.red, slope, behind));
                  c.green = 8'(faded(fill_color.green, slope, behind));
                  c.blue  = 8'(faded(fill_color.blue, slope, behind));
               end
            end
            default: c = '0;
         endcase
      end
      return c;
   endfunction

   always @(posedge clock) begin
      rgb_type want;
      if (reset) begin
         strip_len      = 7'd64;
         fill_color     = '0;
         mismatch_count = 0;
         colors_checked = 0;
         color_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NUM_PIXELS: strip_len = csr_wdata[CNT_W-1:0];
               CSR_FILL_RED:   fill_color.red = csr_wdata;
               CSR_FILL_GREEN: fill_color.green = csr_wdata;
               CSR_FILL_BLUE:  fill_color.blue = csr_wdata;
               default: ;
            endcase
         end
         // compare before queueing, so a word accepted this edge is never matched now
         if (rsp_mon.valid && rsp_mon.ready) begin
            colors_checked++;
            if (color_due.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("%0t: unexpected color word r %0d g %0d b %0d", $realtime,
                           rsp_mon.out_red, rsp_mon.out_green, rsp_mon.out_blue);
               mismatch_count++;
            end else begin
               want = color_due.pop_front();
               if (want.red !== rsp_mon.out_red || want.green !== rsp_mon.out_green ||
                   want.blue !== rsp_mon.out_blue) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display({"%0t: color mismatch, expected r %0d g %0d b %0d,",
                               " got r %0d g %0d b %0d"},
                              $realtime, want.red, want.green, want.blue,
                              rsp_mon.out_red, rsp_mon.out_green, rsp_mon.out_blue);
                  mismatch_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            color_due.push_back(pixel_color(req_mon.mode, req_mon.step, req_mon.phase,
                                            req_mon.pixel_index));
      end
      colors_outstanding = color_due.size();
   end

endmodule

// ===== dv/led_strip_effect_pixel_color_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_effect_pixel_color_tb
// Drives pixel words through the LED strip pixel color block under several
// strip lengths and fill colors, with random gaps and back pressure, while
// the color checker predicts and compares every color word.
// ----------------------------------------------------------------------------
module led_strip_effect_pixel_color_tb
   import lsepc_pkg::*;
();

   localparam int SETUPS          = 10;
   localparam int WORDS_PER_SETUP = 200;
   localparam int STRIP_MAX       = 64;
   localparam int IDLE_LIMIT      = 2000;
   localparam int DRAIN_CYCLES    = 12;

   localparam logic [MODE_W-1:0]  MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_W-1:0]  MODE_SPARE_LAST  = 3'd7;
   localparam logic [PHASE_W-1:0] PHASE_NONE       = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int unsigned mismatch_count;
   int unsigned colors_outstanding;
   int unsigned colors_checked;
   int unsigned words_sent;
   int unsigned setups_done;
   int unsigned idle_cycles;
   int          strip_pixels;
   bit          steady;

   lsepc_req_if req_if();
   lsepc_rsp_if rsp_if();

   led_strip_effect_pixel_color dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lsepc_color_checker color_check (
      .clock              (clock),
      .reset              (reset),
      .req_mon            (req_if),
      .rsp_mon            (rsp_if),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .colors_outstanding (colors_outstanding),
      .colors_checked     (colors_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] fill_level();
      if ($urandom_range(0, 3) == 0) return CSR_DATA_W'($urandom_range(200, 255));
      return CSR_DATA_W'($urandom_range(0, 255));
   endfunction

   task automatic send_word(input logic [MODE_W-1:0]  mode,
                            input logic [STEP_W-1:0]  step,
                            input logic [PHASE_W-1:0] phase,
                            input logic [PIX_W-1:0]   pixel);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.mode        <= mode;
      req_if.step        <= step;
      req_if.phase       <= phase;
      req_if.pixel_index <= pixel;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      words_sent++;
   endtask

   // registers change only with the pipeline empty
   task automatic load_strip(input logic [CSR_DATA_W-1:0] pixels,
                             input logic [CSR_DATA_W-1:0] red,
                             input logic [CSR_DATA_W-1:0] green,
                             input logic [CSR_DATA_W-1:0] blue);
      req_if.valid <= 1'b0;
      while (colors_outstanding != 0) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_NUM_PIXELS;
      csr_wdata <= pixels;
      @(negedge clock);
      csr_index <= CSR_FILL_RED;
      csr_wdata <= red;
      @(negedge clock);
      csr_index <= CSR_FILL_GREEN;
      csr_wdata <= green;
      @(negedge clock);
      csr_index <= CSR_FILL_BLUE;
      csr_wdata <= blue;
      @(negedge clock);
      csr_we <= 1'b0;
      strip_pixels = (pixels[CNT_W-1:0] < STRIP_MAX) ? pixels[CNT_W-1:0] : STRIP_MAX;
      steady       = ($urandom_range(0, 3) == 0);
      setups_done++;
   endtask

   task automatic random_word();
      logic [MODE_W-1:0]  mode;
      logic [STEP_W-1:0]  step;
      logic [PHASE_W-1:0] phase;
      logic [PIX_W-1:0]   pixel;
      if ($urandom_range(0, 9) == 0)
         mode = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      else mode = MODE_W'($urandom_range(MODE_RAINBOW, MODE_METEOR));
      if (strip_pixels > 0 && $urandom_range(0, 9) < 8)
         pixel = PIX_W'($urandom_range(0, strip_pixels - 1));
      else pixel = PIX_W'($urandom_range(0, 63));
      step  = STEP_W'($urandom_range(0, 255));
      phase = ($urandom_range(0, 9) == 0) ? PHASE_NONE : 2'($urandom_range(0, 2));
      // mostly lit chase pixels and pixels on the meteor tail
      if ((mode == MODE_CHASE || mode == MODE_CHASE_RAINBOW) && $urandom_range(0, 1) == 1)
         phase = 2'(pixel % 3);
      if (mode == MODE_METEOR && $urandom_range(0, 3) != 0)
         step = 8'(pixel + $urandom_range(0, 16));
      send_word(mode, step, phase, pixel);
   endtask

   initial begin
      int stall;
      stall        = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            rsp_if.ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("led_strip_effect_pixel_color_tb failed");
            $finish;
         end
      end
   end

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_NUM_PIXELS;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.mode        = MODE_RAINBOW;
      req_if.step        = '0;
      req_if.phase       = '0;
      req_if.pixel_index = '0;
      words_sent         = 0;
      setups_done        = 0;
      strip_pixels       = STRIP_MAX;
      steady             = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // field extremes, every effect, chase hit and miss, meteor head and tail ends
      load_strip(8'd64, 8'd255, 8'd210, 8'd199);
      send_word(MODE_RAINBOW, 8'd0, 2'd0, 6'd0);
      send_word(MODE_RAINBOW, 8'd255, 2'd0, 6'd63);
      send_word(MODE_CYCLE, 8'd0, 2'd0, 6'd63);
      send_word(MODE_CYCLE, 8'd255, 2'd1, 6'd1);
      send_word(MODE_CHASE, 8'd7, 2'd0, 6'd0);
      send_word(MODE_CHASE, 8'd7, 2'd1, 6'd4);
      send_word(MODE_CHASE, 8'd7, 2'd0, 6'd5);
      send_word(MODE_CHASE, 8'd7, PHASE_NONE, 6'd3);
      send_word(MODE_CHASE_RAINBOW, 8'd255, 2'd0, 6'd63);
      send_word(MODE_CHASE_RAINBOW, 8'd0, 2'd2, 6'd2);
      send_word(MODE_CHASE_RAINBOW, 8'd250, 2'd1, 6'd7);
      send_word(MODE_CHASE_RAINBOW, 8'd9, PHASE_NONE, 6'd6);
      send_word(MODE_METEOR, 8'd10, 2'd0, 6'd10);
      send_word(MODE_METEOR, 8'd11, 2'd0, 6'd10);
      send_word(MODE_METEOR, 8'd24, 2'd0, 6'd10);
      send_word(MODE_METEOR, 8'd25, 2'd0, 6'd10);
      send_word(MODE_METEOR, 8'd5, 2'd0, 6'd10);
      send_word(MODE_SPARE_FIRST, 8'd40, 2'd1, 6'd20);
      send_word(MODE_SPARE_FIRST + 3'd1, 8'd40, 2'd2, 6'd21);
      send_word(MODE_SPARE_LAST, 8'd255, PHASE_NONE, 6'd63);

      // short strip with flat meteor fade, then an empty strip
      load_strip(8'd10, 8'd0, 8'd199, 8'd200);
      send_word(MODE_RAINBOW, 8'd3, 2'd0, 6'd10);
      send_word(MODE_CHASE, 8'd3, 2'd0, 6'd63);
      send_word(MODE_METEOR, 8'd3, 2'd0, 6'd3);
      send_word(MODE_METEOR, 8'd4, 2'd0, 6'd3);
      load_strip(8'd0, 8'd255, 8'd255, 8'd255);
      send_word(MODE_CYCLE, 8'd0, 2'd0, 6'd0);

      for (int k = 0; k < SETUPS; k++) begin
         case (k)
            0: load_strip(8'd1, 8'd255, 8'd255, 8'd255);
            1: load_strip(8'd64, 8'd0, 8'd0, 8'd0);
            2: load_strip(8'd0, 8'd200, 8'd13, 8'd255);
            3: load_strip(8'd255, 8'd199, 8'd199, 8'd199);
            4: load_strip(8'd3, 8'd0, 8'd255, 8'd214);
            default: load_strip(CSR_DATA_W'($urandom_range(1, 64)), fill_level(),
                                fill_level(), fill_level());
         endcase
         repeat (WORDS_PER_SETUP) random_word();
      end

      req_if.valid <= 1'b0;
      while (colors_outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("sent %0d pixel words over %0d strip setups, all effects and spare mode codes",
               words_sent, setups_done);
      $display("checked %0d color words, %0d mismatches", colors_checked, mismatch_count);
      if (mismatch_count == 0 && colors_outstanding == 0) begin
         $display("led_strip_effect_pixel_color_tb passed");
      end else begin
         $display("led_strip_effect_pixel_color_tb failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/lsepc_pkg.sv
src/lsepc_req_if.sv
src/lsepc_rsp_if.sv
src/lsepc_div_slice.sv
src/lsepc_front.sv
src/lsepc_back.sv
src/led_strip_effect_pixel_color.sv
dv/lsepc_color_checker.sv
dv/led_strip_effect_pixel_color_tb.sv
